@@ rtl/core/scc_source_sink_counter_macros.svh @@
// Assertion macros used by the checker file of the component counter.
`ifndef SCC_SOURCE_SINK_COUNTER_MACROS_SVH
`define SCC_SOURCE_SINK_COUNTER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SCC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("scc assertion failed");

// Next-cycle implication, held off during reset.
`define SCC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("scc assertion failed");

`endif

@@ rtl/core/scc_pkg.sv @@
// Types and sequencer states of the component counter.
package scc_pkg;

	typedef struct packed {
		logic       action;
		logic [7:0] src_node;
		logic [7:0] dst_node;
	} item_t;

	typedef struct packed {
		logic [7:0] sources_needed;
		logic [7:0] edges_needed;
		logic [7:0] component_count;
		logic       edges_dropped;
	} result_t;

	localparam logic ACT_ADD = 1'b0;
	localparam logic ACT_RUN = 1'b1;

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_ADD, ST_ROOT, ST_RCHK, ST_HEAD, ST_LOOP, ST_EDGE,
		ST_VCHK, ST_POP, ST_POPW, ST_FPOP, ST_PAR, ST_P2U, ST_P2H, ST_P2L,
		ST_P2E, ST_P2V, ST_CNT, ST_CNTW, ST_RES
	} state_t;

endpackage

@@ rtl/core/scc_ram.sv @@
// Simple dual-port memory: one write port, one registered read port.
module scc_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/scc_source_sink_counter.sv @@
// Top level of the strongly connected component source/sink counter.
//
// Usage: drive item and raise start; the word is taken at a rising edge with
// start high and busy low. An add word (action 0) stores one directed edge in
// the edge memory; a bad edge (endpoint 0 or above the node count, or store
// full) is dropped and latched in the drop flag.
// A run word (action 1) walks the graph with Tarjan's method on an explicit
// frame stack held in memory, then classifies inter-component edges and
// counts sources and sinks. The node and edge memories are read through
// registered read ports, and a clearing pass over all MAX_NODES entries
// follows the result. The classifying and counting passes are skipped when a
// single component covers the graph.
// The result appears on result for exactly one cycle with done high; the
// receiver cannot stall it. After reset the block runs the same clearing pass
// with busy high; wr_en writes node_count at any time the block is idle.
module scc_source_sink_counter
	import scc_pkg::*;
#(
	parameter int MAX_NODES = 128,
	parameter int MAX_EDGES = 16384
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  item_t      item,
	input  logic       wr_en,
	input  logic [7:0] wr_data,
	output logic       done,
	output result_t    result
);

	localparam int NI  = $clog2(MAX_NODES);
	localparam int EIW = $clog2(MAX_EDGES);
	localparam int EW  = $clog2(MAX_EDGES + 1);
	localparam int FW  = NI + EW + 16;

	state_t state_q, state_nx;

	logic [7:0]    cfg_q, n_eff, n_q;
	logic [EW-1:0] total_q;
	logic          drop_q;
	logic [7:0]    r_q, order_q, sp_q, fp_q, comps_q, k_q, srcc_q, sinkc_q;
	logic [NI-1:0] u_q, clr_q;
	logic [EW-1:0] nxt_q;
	logic [7:0]    visu_q, lowu_q, v_q, cu_q;
	logic [7:0]    s_q, d_q;

	// memory ports
	logic          hd_we;  logic [NI-1:0] hd_wa, hd_ra;  logic [EW-1:0] hd_wd, hd_rd;
	logic          ed_we;  logic [EIW-1:0] ed_wa, ed_ra; logic [8+EW-1:0] ed_wd, ed_rd;
	logic          vi_we;  logic [NI-1:0] vi_wa, vi_ra;  logic [7:0] vi_wd, vi_rd;
	logic          mt_we;  logic [NI-1:0] mt_wa, mt_ra;  logic [8:0] mt_wd, mt_rd;
	logic          sk_we;  logic [NI-1:0] sk_wa, sk_ra;  logic [NI-1:0] sk_wd, sk_rd;
	logic          fr_we;  logic [NI-1:0] fr_wa, fr_ra;  logic [FW-1:0] fr_wd, fr_rd;
	logic          hi_we;  logic [NI-1:0] hi_wa, hi_ra;  logic hi_wd, hi_rd;
	logic          ho_we;  logic [NI-1:0] ho_wa, ho_ra;  logic ho_wd, ho_rd;

	scc_ram #(.DEPTH(MAX_NODES), .WIDTH(EW)) u_head (.clk(clk), .we(hd_we),
		.waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
	scc_ram #(.DEPTH(MAX_EDGES), .WIDTH(8 + EW)) u_edge (.clk(clk), .we(ed_we),
		.waddr(ed_wa), .wdata(ed_wd), .raddr(ed_ra), .rdata(ed_rd));
	scc_ram #(.DEPTH(MAX_NODES), .WIDTH(8)) u_visit (.clk(clk), .we(vi_we),
		.waddr(vi_wa), .wdata(vi_wd), .raddr(vi_ra), .rdata(vi_rd));
	scc_ram #(.DEPTH(MAX_NODES), .WIDTH(9)) u_meta (.clk(clk), .we(mt_we),
		.waddr(mt_wa), .wdata(mt_wd), .raddr(mt_ra), .rdata(mt_rd));
	scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NI)) u_stack (.clk(clk), .we(sk_we),
		.waddr(sk_wa), .wdata(sk_wd), .raddr(sk_ra), .rdata(sk_rd));
	scc_ram #(.DEPTH(MAX_NODES), .WIDTH(FW)) u_frame (.clk(clk), .we(fr_we),
		.waddr(fr_wa), .wdata(fr_wd), .raddr(fr_ra), .rdata(fr_rd));
	scc_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_hin (.clk(clk), .we(hi_we),
		.waddr(hi_wa), .wdata(hi_wd), .raddr(hi_ra), .rdata(hi_rd));
	scc_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_hout (.clk(clk), .we(ho_we),
		.waddr(ho_wa), .wdata(ho_wd), .raddr(ho_ra), .rdata(ho_rd));

	// read data views
	logic [7:0]    ed_tgt;
	logic [EW-1:0] ed_lnk;
	logic [7:0]    mt_comp;
	logic          mt_on;
	logic [NI-1:0] fr_node;
	logic [EW-1:0] fr_next;
	logic [7:0]    fr_low, fr_vis;
	assign {ed_tgt, ed_lnk} = ed_rd;
	assign {mt_comp, mt_on} = mt_rd;
	assign {fr_node, fr_next, fr_low, fr_vis} = fr_rd;

	// saturate the node count
	assign n_eff = (cfg_q == 8'd0) ? 8'd1 :
		((32'(cfg_q) > MAX_NODES) ? 8'(MAX_NODES) : cfg_q);

	logic take, add_bad, tgt_bad, last_clr;
	assign take    = start && (state_q == ST_IDLE);
	assign add_bad = (item.src_node == 8'd0) || (item.src_node > n_eff) ||
		(item.dst_node == 8'd0) || (item.dst_node > n_eff) ||
		(32'(total_q) >= MAX_EDGES);
	assign tgt_bad  = (ed_tgt == 8'd0) || (ed_tgt > n_q);
	assign last_clr = (clr_q == NI'(MAX_NODES - 1));

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLR:  if (last_clr) state_nx = ST_IDLE;
			ST_IDLE: begin
				if (take && item.action == ACT_RUN) state_nx = ST_ROOT;
				else if (take && !add_bad) state_nx = ST_ADD;
			end
			ST_ADD:  state_nx = ST_IDLE;
			ST_ROOT: begin
				if (r_q != n_q) state_nx = ST_RCHK;
				else if (comps_q == 8'd1) state_nx = ST_RES;
				else state_nx = ST_P2U;
			end
			ST_RCHK: state_nx = (vi_rd != 8'd0) ? ST_ROOT : ST_HEAD;
			ST_HEAD: state_nx = ST_LOOP;
			ST_LOOP: begin
				if (nxt_q != '0) state_nx = ST_EDGE;
				else if (visu_q == lowu_q) state_nx = ST_POP;
				else state_nx = ST_FPOP;
			end
			ST_EDGE: state_nx = tgt_bad ? ST_LOOP : ST_VCHK;
			ST_VCHK: state_nx = (vi_rd == 8'd0) ? ST_HEAD : ST_LOOP;
			ST_POP:  state_nx = ST_POPW;
			ST_POPW: state_nx = (sk_rd != u_q && (sp_q - 8'd1) != 8'd0) ? ST_POP : ST_FPOP;
			ST_FPOP: state_nx = ((fp_q - 8'd1) != 8'd0) ? ST_PAR : ST_ROOT;
			ST_PAR:  state_nx = ST_LOOP;
			ST_P2U:  state_nx = (r_q == n_q) ? ST_CNT : ST_P2H;
			ST_P2H:  state_nx = ST_P2L;
			ST_P2L:  state_nx = (nxt_q != '0) ? ST_P2E : ST_P2U;
			ST_P2E:  state_nx = tgt_bad ? ST_P2L : ST_P2V;
			ST_P2V:  state_nx = ST_P2L;
			ST_CNT:  state_nx = (k_q == comps_q) ? ST_RES : ST_CNTW;
			ST_CNTW: state_nx = ST_CNT;
			ST_RES:  state_nx = ST_CLR;
			default: state_nx = ST_CLR;
		endcase
	end

	// memory controls
	always_comb begin
		hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = '0;
		ed_we = 1'b0; ed_wa = '0; ed_wd = '0; ed_ra = '0;
		vi_we = 1'b0; vi_wa = '0; vi_wd = '0; vi_ra = '0;
		mt_we = 1'b0; mt_wa = '0; mt_wd = '0; mt_ra = '0;
		sk_we = 1'b0; sk_wa = '0; sk_wd = '0; sk_ra = '0;
		fr_we = 1'b0; fr_wa = '0; fr_wd = '0; fr_ra = '0;
		hi_we = 1'b0; hi_wa = '0; hi_wd = 1'b0; hi_ra = '0;
		ho_we = 1'b0; ho_wa = '0; ho_wd = 1'b0; ho_ra = '0;
		case (state_q)
			ST_CLR: begin
				hd_we = 1'b1; hd_wa = clr_q;
				vi_we = 1'b1; vi_wa = clr_q;
				mt_we = 1'b1; mt_wa = clr_q;
				hi_we = 1'b1; hi_wa = clr_q;
				ho_we = 1'b1; ho_wa = clr_q;
			end
			ST_IDLE: hd_ra = NI'(item.src_node - 8'd1);
			ST_ADD: begin
				ed_we = 1'b1; ed_wa = EIW'(total_q); ed_wd = {d_q, hd_rd};
				hd_we = 1'b1; hd_wa = NI'(s_q - 8'd1); hd_wd = total_q + EW'(1);
			end
			ST_ROOT: vi_ra = NI'(r_q);
			ST_RCHK: begin
				if (vi_rd == 8'd0) begin
					vi_we = 1'b1; vi_wa = NI'(r_q); vi_wd = order_q + 8'd1;
					mt_we = 1'b1; mt_wa = NI'(r_q); mt_wd = {8'd0, 1'b1};
					sk_we = 1'b1; sk_wa = NI'(sp_q); sk_wd = NI'(r_q);
					hd_ra = NI'(r_q);
				end
			end
			ST_LOOP: ed_ra = EIW'(nxt_q - EW'(1));
			ST_EDGE: begin
				vi_ra = NI'(ed_tgt - 8'd1);
				mt_ra = NI'(ed_tgt - 8'd1);
			end
			ST_VCHK: begin
				if (vi_rd == 8'd0) begin
					fr_we = 1'b1; fr_wa = NI'(fp_q - 8'd1);
					fr_wd = {u_q, nxt_q, lowu_q, visu_q};
					vi_we = 1'b1; vi_wa = NI'(v_q - 8'd1); vi_wd = order_q + 8'd1;
					mt_we = 1'b1; mt_wa = NI'(v_q - 8'd1); mt_wd = {8'd0, 1'b1};
					sk_we = 1'b1; sk_wa = NI'(sp_q); sk_wd = NI'(v_q - 8'd1);
					hd_ra = NI'(v_q - 8'd1);
				end
			end
			ST_POP:  sk_ra = NI'(sp_q - 8'd1);
			ST_POPW: begin
				mt_we = 1'b1; mt_wa = sk_rd; mt_wd = {comps_q, 1'b0};
			end
			ST_FPOP: fr_ra = NI'(fp_q - 8'd2);
			ST_P2U: begin
				hd_ra = NI'(r_q);
				mt_ra = NI'(r_q);
			end
			ST_P2L: ed_ra = EIW'(nxt_q - EW'(1));
			ST_P2E: mt_ra = NI'(ed_tgt - 8'd1);
			ST_P2V: begin
				if (mt_comp != cu_q) begin
					ho_we = 1'b1; ho_wa = NI'(cu_q - 8'd1); ho_wd = 1'b1;
					hi_we = 1'b1; hi_wa = NI'(mt_comp - 8'd1); hi_wd = 1'b1;
				end
			end
			ST_CNT: begin
				hi_ra = NI'(k_q);
				ho_ra = NI'(k_q);
			end
			default: ;
		endcase
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			cfg_q   <= 8'd1;
			total_q <= '0;
			drop_q  <= 1'b0;
			clr_q   <= '0;
			r_q     <= '0;
			order_q <= '0;
			sp_q    <= '0;
			fp_q    <= '0;
			comps_q <= '0;
			k_q     <= '0;
			n_q     <= 8'd1;
		end else begin
			state_q <= state_nx;
			if (wr_en) cfg_q <= wr_data;
			case (state_q)
				ST_CLR: clr_q <= clr_q + NI'(1);
				ST_IDLE: begin
					if (take && item.action == ACT_RUN) begin
						n_q <= n_eff; r_q <= '0; order_q <= '0;
						sp_q <= '0; fp_q <= '0; comps_q <= '0;
					end else if (take && add_bad) begin
						drop_q <= 1'b1;
					end else if (take) begin
						s_q <= item.src_node;
						d_q <= item.dst_node;
					end
				end
				ST_ADD: total_q <= total_q + EW'(1);
				ST_RCHK: begin
					if (vi_rd != 8'd0) begin
						r_q <= r_q + 8'd1;
					end else begin
						// open the root frame
						order_q <= order_q + 8'd1;
						visu_q  <= order_q + 8'd1;
						lowu_q  <= order_q + 8'd1;
						u_q     <= NI'(r_q);
						sp_q    <= sp_q + 8'd1;
						fp_q    <= 8'd1;
					end
				end
				ST_HEAD: nxt_q <= hd_rd;
				ST_EDGE: begin
					nxt_q <= ed_lnk;
					v_q   <= ed_tgt;
				end
				ST_VCHK: begin
					if (vi_rd == 8'd0) begin
						// descend into the new node
						order_q <= order_q + 8'd1;
						visu_q  <= order_q + 8'd1;
						lowu_q  <= order_q + 8'd1;
						u_q     <= NI'(v_q - 8'd1);
						sp_q    <= sp_q + 8'd1;
						fp_q    <= fp_q + 8'd1;
					end else if (mt_on && lowu_q > vi_rd) begin
						lowu_q <= vi_rd;
					end
				end
				ST_LOOP: if (nxt_q == '0 && visu_q == lowu_q) comps_q <= comps_q + 8'd1;
				ST_POPW: sp_q <= sp_q - 8'd1;
				ST_FPOP: begin
					fp_q <= fp_q - 8'd1;
					if ((fp_q - 8'd1) == 8'd0) r_q <= r_q + 8'd1;
				end
				ST_PAR: begin
					u_q    <= fr_node;
					nxt_q  <= fr_next;
					visu_q <= fr_vis;
					lowu_q <= (lowu_q < fr_low) ? lowu_q : fr_low;
				end
				ST_ROOT: begin
					if (r_q == n_q) begin
						r_q <= '0; k_q <= '0; srcc_q <= '0; sinkc_q <= '0;
					end
				end
				ST_P2H: begin
					nxt_q <= hd_rd;
					cu_q  <= mt_comp;
				end
				ST_P2L: if (nxt_q == '0) r_q <= r_q + 8'd1;
				ST_P2E: nxt_q <= ed_lnk;
				ST_CNTW: begin
					if (!hi_rd) srcc_q  <= srcc_q + 8'd1;
					if (!ho_rd) sinkc_q <= sinkc_q + 8'd1;
					k_q <= k_q + 8'd1;
				end
				ST_RES: begin
					// drop the edge store
					clr_q   <= '0;
					total_q <= '0;
					drop_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RES);

	always_comb begin
		result.component_count = comps_q;
		result.edges_dropped   = drop_q;
		if (comps_q == 8'd1) begin
			result.sources_needed = 8'd1;
			result.edges_needed   = 8'd0;
		end else begin
			result.sources_needed = srcc_q;
			result.edges_needed   = (srcc_q > sinkc_q) ? srcc_q : sinkc_q;
		end
	end

endmodule

@@ rtl/core/scc_chk.sv @@
// Port checker of the component counter and its bind.
`include "scc_source_sink_counter_macros.svh"

module scc_chk
	import scc_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  start,
	input logic  busy,
	input item_t item,
	input logic  done
);

	`SCC_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy)
	`SCC_ASSERT_NXT(a_done_once, clk, arst_n, done, !done)
	`SCC_ASSERT_NXT(a_add_quiet, clk, arst_n, start && !busy && item.action == ACT_ADD, !done)
	`SCC_ASSERT_NXT(a_run_busy, clk, arst_n, start && !busy && item.action == ACT_RUN, busy)

endmodule

bind scc_source_sink_counter scc_chk u_scc_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item), .done(done)
);

@@ sim/scc_source_sink_counter_test.sv @@
// Self-checking testbench for the strongly connected component source/sink counter.
`timescale 1ns / 1ps

module scc_source_sink_counter_test;
	import scc_pkg::*;

	localparam int NODE_LIMIT = 128;
	localparam int EDGE_LIMIT = 16384;
	localparam int CYCLE_LIMIT = 3000000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	item_t   item = '0;
	logic    wr_en = 1'b0;
	logic    [7:0] wr_data = 8'd0;
	logic    done;
	result_t result;

	scc_source_sink_counter DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.done    (done),
		.result  (result)
	);

	always #10 clk = ~clk;

	// Words waiting to go out, and results the predictor says must come back.
	item_t   words_to_send[$];
	result_t expected_results[$];

	// Shadow copy of the block's state: node count register, stored edges, drop flag.
	logic [7:0] shadow_node_count = 8'd1;
	logic [7:0] stored_src[$];
	logic [7:0] stored_dst[$];
	bit         shadow_dropped = 1'b0;

	int mismatches = 0;
	int runs_checked = 0;
	int words_sent = 0;
	int cycle_count = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH run %0d: %s got %0d want %0d", runs_checked, what, got, want);
		mismatches++;
	endtask

	// Zero counts as one node, anything above the limit saturates.
	function automatic int active_nodes();
		int n;
		n = int'(shadow_node_count);
		if (n == 0) n = 1;
		if (n > NODE_LIMIT) n = NODE_LIMIT;
		return n;
	endfunction

	// Components by mutual reachability: same partition as a depth-first walk
	// would give, so the source and sink counts match whatever order is used.
	function automatic result_t count_sources_sinks();
		logic [NODE_LIMIT-1:0] reach [NODE_LIMIT];
		int      leader [NODE_LIMIT];
		bit      fed [NODE_LIMIT];
		bit      feeds [NODE_LIMIT];
		int      n, comps, srcs, sinks;
		result_t r;
		n = active_nodes();
		for (int i = 0; i < NODE_LIMIT; i++) begin
			reach[i] = '0;
			reach[i][i] = 1'b1;
			fed[i] = 1'b0;
			feeds[i] = 1'b0;
		end
		// Drop edges that touch nodes beyond the current count.
		for (int e = 0; e < stored_src.size(); e++)
			if (stored_src[e] <= n && stored_dst[e] <= n)
				reach[stored_src[e] - 1][stored_dst[e] - 1] = 1'b1;
		for (int k = 0; k < n; k++)
			for (int i = 0; i < n; i++)
				if (reach[i][k]) reach[i] |= reach[k];
		comps = 0;
		for (int i = 0; i < n; i++) begin
			leader[i] = i;
			for (int j = 0; j < i; j++)
				if (reach[i][j] && reach[j][i] && leader[i] == i) leader[i] = j;
			if (leader[i] == i) comps++;
		end
		for (int e = 0; e < stored_src.size(); e++)
			if (stored_src[e] <= n && stored_dst[e] <= n &&
			    leader[stored_src[e] - 1] != leader[stored_dst[e] - 1]) begin
				feeds[leader[stored_src[e] - 1]] = 1'b1;
				fed[leader[stored_dst[e] - 1]] = 1'b1;
			end
		srcs = 0;
		sinks = 0;
		for (int i = 0; i < n; i++)
			if (leader[i] == i) begin
				if (!fed[i]) srcs++;
				if (!feeds[i]) sinks++;
			end
		if (comps == 1) begin
			r.sources_needed = 8'd1;
			r.edges_needed = 8'd0;
		end else begin
			r.sources_needed = srcs[7:0];
			r.edges_needed = (srcs > sinks) ? srcs[7:0] : sinks[7:0];
		end
		r.component_count = comps[7:0];
		r.edges_dropped = shadow_dropped;
		return r;
	endfunction

	// Advance the shadow state by one accepted word.
	function automatic void absorb_word(input item_t w);
		int n;
		n = active_nodes();
		if (w.action == ACT_ADD) begin
			if (w.src_node == 0 || w.src_node > n || w.dst_node == 0 ||
			    w.dst_node > n || stored_src.size() >= EDGE_LIMIT)
				shadow_dropped = 1'b1;
			else begin
				stored_src.push_back(w.src_node);
				stored_dst.push_back(w.dst_node);
			end
		end else begin
			expected_results.push_back(count_sources_sinks());
			stored_src.delete();
			stored_dst.delete();
			shadow_dropped = 1'b0;
		end
	endfunction

	// Mostly back to back, sometimes a short pause, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Driver: hold the head word until taken, then draw a gap before the next.
	int gap_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				absorb_word(words_to_send.pop_front());
				words_sent++;
				gap_left = pick_gap();
			end else if (!start && gap_left > 0) begin
				gap_left--;
			end
			if (gap_left == 0 && words_to_send.size() > 0) begin
				start <= 1'b1;
				item <= words_to_send[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobed result must match the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", 1, 0);
			end else begin
				want = expected_results.pop_front();
				if (result.sources_needed !== want.sources_needed)
					report_mismatch("sources_needed", int'(result.sources_needed),
						int'(want.sources_needed));
				if (result.edges_needed !== want.edges_needed)
					report_mismatch("edges_needed", int'(result.edges_needed),
						int'(want.edges_needed));
				if (result.component_count !== want.component_count)
					report_mismatch("component_count", int'(result.component_count),
						int'(want.component_count));
				if (result.edges_dropped !== want.edges_dropped)
					report_mismatch("edges_dropped", int'(result.edges_dropped),
						int'(want.edges_dropped));
				runs_checked++;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("scc_source_sink_counter_test: errors");
			$finish;
		end
	end

	task automatic push_word(input logic act, input int s, input int d);
		item_t w;
		w.action = act;
		w.src_node = s[7:0];
		w.dst_node = d[7:0];
		words_to_send.push_back(w);
	endtask

	// Drain everything, then hold until busy has stayed low for a while.
	task automatic wait_idle();
		int quiet;
		quiet = 0;
		while (quiet < 8) begin
			@(posedge clk);
			if (busy || start || words_to_send.size() > 0 || expected_results.size() > 0)
				quiet = 0;
			else
				quiet++;
		end
	endtask

	task automatic write_node_count(input int value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_data <= value[7:0];
		shadow_node_count = value[7:0];
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// One random graph then a run: mostly legal edges, some rings to build
	// bigger components, a sprinkle of out-of-range endpoints.
	task automatic queue_graph();
		int n, edges, r, ring_len, first, prev, nxt;
		n = active_nodes();
		edges = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
			: $urandom_range(0, (2 * n < 30) ? 2 * n : 30);
		for (int e = 0; e < edges; e++) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				push_word(ACT_ADD, $urandom_range(0, 255), $urandom_range(0, 255));
			end else if (r < 12 && n > 1) begin
				ring_len = $urandom_range(2, (n < 6) ? n : 6);
				first = $urandom_range(1, n);
				prev = first;
				for (int k = 1; k < ring_len; k++) begin
					nxt = $urandom_range(1, n);
					push_word(ACT_ADD, prev, nxt);
					prev = nxt;
				end
				push_word(ACT_ADD, prev, first);
			end else begin
				push_word(ACT_ADD, $urandom_range(1, n), $urandom_range(1, n));
			end
		end
		push_word(ACT_RUN, $urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	initial begin
		int pick, graphs;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// Directed: empty single node graph at reset count, then a ring plus self loop.
		push_word(ACT_RUN, 0, 0);
		wait_idle();
		write_node_count(4);
		push_word(ACT_ADD, 1, 2);
		push_word(ACT_ADD, 2, 3);
		push_word(ACT_ADD, 3, 1);
		push_word(ACT_ADD, 4, 4);
		push_word(ACT_ADD, 0, 2);
		push_word(ACT_ADD, 255, 1);
		push_word(ACT_RUN, 255, 255);
		// Whole graph one component: single component answer.
		push_word(ACT_ADD, 1, 2);
		push_word(ACT_ADD, 2, 1);
		push_word(ACT_ADD, 2, 3);
		push_word(ACT_ADD, 3, 4);
		push_word(ACT_ADD, 4, 1);
		push_word(ACT_RUN, 0, 0);
		wait_idle();
		// Lower the node count after loading edges past it.
		write_node_count(8);
		push_word(ACT_ADD, 1, 7);
		push_word(ACT_ADD, 7, 1);
		push_word(ACT_ADD, 8, 2);
		push_word(ACT_ADD, 2, 3);
		wait_idle();
		write_node_count(3);
		push_word(ACT_RUN, 0, 0);
		wait_idle();
		// Zero and oversized counts.
		write_node_count(0);
		push_word(ACT_ADD, 1, 1);
		push_word(ACT_ADD, 2, 1);
		push_word(ACT_RUN, 0, 0);
		wait_idle();
		write_node_count(255);
		push_word(ACT_ADD, 128, 1);
		push_word(ACT_ADD, 129, 1);
		push_word(ACT_RUN, 0, 0);
		wait_idle();

		// Random phases over a spread of node counts, extremes included.
		while (words_sent < 1300) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: write_node_count(1);
				1: write_node_count(128);
				2: write_node_count($urandom_range(129, 255));
				3: write_node_count(0);
				4, 5: write_node_count($urandom_range(2, 4));
				default: write_node_count($urandom_range(2, 20));
			endcase
			graphs = $urandom_range(1, 4);
			for (int g = 0; g < graphs; g++) queue_graph();
			wait_idle();
		end

		repeat (200) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never arrived", expected_results.size(), 0);
		$display("covered %0d words and %0d checked runs of random graphs",
			words_sent, runs_checked);
		$display("node counts from zero to 255, %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("scc_source_sink_counter_test: clean");
		else
			$display("scc_source_sink_counter_test: errors");
		$finish;
	end

endmodule
